// ===== hw/rtl/eie_pkg.sv =====
// Shared types, constants and helper functions of the embedded image extractor.
// Used by eie_header_det, eie_pixel_conv and embedded_image_extractor_unit.
// No dependencies.
`timescale 1ns / 1ps

package eie_pkg;

   // Width of the stream position counter.
   localparam int POS_BITS = 32;
   // Width used for position and size comparisons; holds pos + 15 + 3 * 2^32.
   localparam int CMP_W = ((POS_BITS > 32) ? POS_BITS : 32) + 3;
   localparam logic [CMP_W-1:0] POS_MASK = {{(CMP_W - POS_BITS){1'b0}}, {POS_BITS{1'b1}}};

   localparam logic [7:0] MARK_WIDE    = 8'h04;
   localparam logic [7:0] MARK_NARROW0 = 8'h06;
   localparam logic [7:0] MARK_NARROW1 = 8'h07;
   localparam logic [7:0] MARK_TAIL    = 8'h10;

   // Bytes skipped between the header tail byte and the first pixel byte.
   localparam logic [3:0] HEADER_GAP = 4'd14;

   // Configuration register indexes.
   localparam logic CSR_STREAM_LENGTH = 1'b0;
   localparam logic CSR_IMAGE_LIMIT   = 1'b1;

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_SKIP,
      PH_PIXELS,
      PH_RESUME
   } phase_type;

   typedef struct packed {
      logic        hit;
      logic        wide;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] area;
   } header_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] image_index;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        first_of_image;
      logic        last_of_image;
      logic        stream_done;
      logic [11:0] image_count;
   } result_type;

   // floor(x * 255 / 31) for every 5-bit channel value.
   localparam logic [7:0] SCALE5_LUT [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   function automatic logic [7:0] scale5(input logic [4:0] x);
      return SCALE5_LUT[x];
   endfunction

endpackage

// ===== hw/rtl/eie_header_det.sv =====
// Header detector: byte history, registered image area products and the header match.
// Depends on eie_pkg.
`timescale 1ns / 1ps

module eie_header_det (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [7:0]                  data_byte,
   input  logic                        scan_en,
   input  logic [eie_pkg::POS_BITS-1:0] position,
   input  logic [31:0]                 stream_length,
   input  logic [11:0]                 image_limit,
   input  logic [11:0]                 images_found,
   output eie_pkg::header_type         header
);
   import eie_pkg::*;

   logic [7:0]  hist_ff [5];
   logic [7:0]  hist_in [5];
   logic [31:0] area_ff, area_in;
   logic [33:0] area3_ff, area3_in;

   logic [15:0]      cur_width, cur_height, next_width, next_height;
   logic             wide, narrow, in_range, fits;
   logic [33:0]      byte_count;
   logic [CMP_W-1:0] pos_ext, len_ext;

   // The area registers always hold the products for the sizes that sit in the
   // history, computed one byte ahead from the bytes that are about to shift in.
   always_comb begin
      next_width  = {hist_ff[2], hist_ff[3]};
      next_height = {hist_ff[0], hist_ff[1]};
      area_in     = next_width * next_height;
      area3_in    = (18'(next_width) + {1'b0, next_width, 1'b0}) * next_height;
      hist_in[0]  = data_byte;
      for (int k = 1; k < 5; k++) begin
         hist_in[k] = hist_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            hist_ff[k] <= '0;
         end
         area_ff  <= '0;
         area3_ff <= '0;
      end else if (advance) begin
         hist_ff  <= hist_in;
         area_ff  <= area_in;
         area3_ff <= area3_in;
      end
   end

   always_comb begin
      cur_width  = {hist_ff[3], hist_ff[4]};
      cur_height = {hist_ff[1], hist_ff[2]};
      wide       = (hist_ff[0] == MARK_WIDE);
      narrow     = (hist_ff[0] == MARK_NARROW0) || (hist_ff[0] == MARK_NARROW1);
      pos_ext    = CMP_W'(position);
      len_ext    = CMP_W'(stream_length);
      in_range   = (pos_ext >= CMP_W'(5)) && ((pos_ext + CMP_W'(9)) < len_ext);
      byte_count = wide ? area3_ff : {1'b0, area_ff, 1'b0};
      fits       = (pos_ext + CMP_W'(15) + CMP_W'(byte_count)) <= len_ext;

      header.hit    = scan_en && in_range && (images_found < image_limit) &&
                      (data_byte == MARK_TAIL) && (wide || narrow) &&
                      (cur_width != '0) && (cur_height != '0) && fits;
      header.wide   = wide;
      header.width  = cur_width;
      header.height = cur_height;
      header.area   = area_ff;
   end

endmodule

// ===== hw/rtl/eie_pixel_conv.sv =====
// Pixel converter: turns a 15-bit or 24-bit BGR pixel into 8-bit RGB channels.
// Depends on eie_pkg for the channel scaling table.
`timescale 1ns / 1ps

module eie_pixel_conv (
   input  logic                 wide,
   input  logic [15:0]          partial,
   input  logic [7:0]           data_byte,
   output eie_pkg::rgb_type     rgb
);
   import eie_pkg::*;

   logic [15:0] packed_px;

   always_comb begin
      packed_px = partial | {data_byte, 8'h00};
      if (wide) begin
         rgb.blue  = partial[7:0];
         rgb.green = partial[15:8];
         rgb.red   = data_byte;
      end else begin
         rgb.red   = scale5(packed_px[4:0]);
         rgb.green = scale5(packed_px[9:5]);
         rgb.blue  = scale5(packed_px[14:10]);
      end
   end

endmodule

// ===== hw/rtl/embedded_image_extractor_unit.sv =====
// Top level of the embedded image extractor: request register, phase control,
// pixel counters and result register. Depends on eie_pkg, eie_header_det, eie_pixel_conv.
//
// Usage: program stream_length (index 0) and image_limit (index 1) on the csr_
// channel while the block is idle, then stream the bytes on req_ one per request.
// Each byte that completes a pixel, and the byte at position stream_length-1,
// produces one result on rsp_; every other byte produces none. rsp_tuser flags a
// pixel, rsp_tlast flags the last stream byte, and both may be high together.
// Throughput is one byte per cycle while the result register is free or being
// taken: the header match, the pixel counters and the pixel conversion all settle
// in the single stage between the request register and the result register; the
// 16x16 area products are computed one byte ahead. A request is captured in the
// request register and its result in the result register, which drives rsp_.
// When the receiver stalls, the result register holds its result and the request
// register holds one byte; with that byte held, req_tready drops until rsp_tready returns.
// Reset clears the history, position, counters and phase, sets stream_length to
// 0 and image_limit to 1000, and needs no clearing pass.
`timescale 1ns / 1ps

module embedded_image_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,    // red, green, blue, image_index, image_width,
                                     // image_height, first_of_image, last_of_image,
                                     // image_count, zero pad
   output logic        rsp_tuser,    // pixel_valid
   output logic        rsp_tlast,    // stream_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import eie_pkg::*;

   logic [31:0] stream_length_ff;
   logic [11:0] image_limit_ff;

   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff;

   phase_type              phase_ff, phase_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic                   wide_ff, wide_in;
   logic [3:0]             skip_ff, skip_in;
   logic [31:0]            pixels_left_ff, pixels_left_in;
   logic [31:0]            total_ff, total_in;
   logic [1:0]             byte_phase_ff, byte_phase_in;
   logic [15:0]            partial_ff, partial_in;
   logic [11:0]            found_ff, found_in;
   logic [15:0]            width_ff, width_in;
   logic [15:0]            height_ff, height_in;

   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       out_free, advance, pix, done, rsp_load;
   logic [1:0] need;
   logic [CMP_W-1:0] last_pos;
   header_type header;
   rgb_type    rgb;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= '0;
         image_limit_ff   <= 12'd1000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STREAM_LENGTH: stream_length_ff <= csr_data;
            CSR_IMAGE_LIMIT:   image_limit_ff   <= csr_data[11:0];
            default:           ;
         endcase
      end
   end

   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_byte_ff <= req_tdata;
      end
   end

   eie_header_det u_header_det (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .data_byte     (req_byte_ff),
      .scan_en       (phase_ff == PH_SCAN),
      .position      (pos_ff),
      .stream_length (stream_length_ff),
      .image_limit   (image_limit_ff),
      .images_found  (found_ff),
      .header        (header)
   );

   eie_pixel_conv u_pixel_conv (
      .wide      (wide_ff),
      .partial   (partial_ff),
      .data_byte (req_byte_ff),
      .rgb       (rgb)
   );

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      wide_in        = wide_ff;
      skip_in        = skip_ff;
      pixels_left_in = pixels_left_ff;
      total_in       = total_ff;
      byte_phase_in  = byte_phase_ff;
      partial_in     = partial_ff;
      found_in       = found_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      pix            = 1'b0;
      rsp_in         = '0;
      need           = wide_ff ? 2'd2 : 2'd1;
      last_pos       = CMP_W'(stream_length_ff - 32'd1) & POS_MASK;
      done           = (stream_length_ff != '0) && (CMP_W'(pos_ff) == last_pos);

      if (advance) begin
         pos_in = pos_ff + POS_BITS'(1);
         unique case (phase_ff)
            PH_SCAN: begin
               if (header.hit) begin
                  width_in       = header.width;
                  height_in      = header.height;
                  wide_in        = header.wide;
                  pixels_left_in = header.area;
                  total_in       = header.area;
                  byte_phase_in  = '0;
                  partial_in     = '0;
                  skip_in        = HEADER_GAP;
                  phase_in       = PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 4'd1;
               if (skip_in == '0) begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               if (byte_phase_ff < need) begin
                  partial_in    = byte_phase_ff[0] ? (partial_ff | {req_byte_ff, 8'h00})
                                                   : (partial_ff | {8'h00, req_byte_ff});
                  byte_phase_in = byte_phase_ff + 2'd1;
               end else begin
                  pix                   = 1'b1;
                  rsp_in.red            = rgb.red;
                  rsp_in.green          = rgb.green;
                  rsp_in.blue           = rgb.blue;
                  rsp_in.image_index    = found_ff;
                  rsp_in.image_width    = width_ff;
                  rsp_in.image_height   = height_ff;
                  rsp_in.first_of_image = (pixels_left_ff == total_ff);
                  rsp_in.last_of_image  = (pixels_left_ff <= 32'd1);
                  byte_phase_in         = '0;
                  partial_in            = '0;
                  if (rsp_in.last_of_image) begin
                     pixels_left_in = '0;
                     found_in       = found_ff + 12'd1;
                     phase_in       = PH_RESUME;
                  end else begin
                     pixels_left_in = pixels_left_ff - 32'd1;
                  end
               end
            end
            PH_RESUME: begin
               phase_in = PH_SCAN;
            end
            default: phase_in = PH_SCAN;
         endcase
      end

      rsp_in.pixel_valid = pix;
      rsp_in.stream_done = done;
      rsp_in.image_count = found_in;
      rsp_load           = advance && (pix || done);

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SCAN;
         pos_ff         <= '0;
         wide_ff        <= 1'b0;
         skip_ff        <= '0;
         pixels_left_ff <= '0;
         total_ff       <= '0;
         byte_phase_ff  <= '0;
         partial_ff     <= '0;
         found_ff       <= '0;
         width_ff       <= '0;
         height_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         wide_ff        <= wide_in;
         skip_ff        <= skip_in;
         pixels_left_ff <= pixels_left_in;
         total_ff       <= total_in;
         byte_phase_ff  <= byte_phase_in;
         partial_ff     <= partial_in;
         found_ff       <= found_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.pixel_valid;
   assign rsp_tlast  = rsp_ff.stream_done;
   assign rsp_tdata  = {6'b0, rsp_ff.image_count, rsp_ff.last_of_image,
                        rsp_ff.first_of_image, rsp_ff.image_height, rsp_ff.image_width,
                        rsp_ff.image_index, rsp_ff.blue, rsp_ff.green, rsp_ff.red};

   // A result without a pixel exists only for the last stream byte.
   a_no_pixel_means_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.pixel_valid) |-> rsp_ff.stream_done)
      else $error("result without pixel is not the stream end");

   // The header gap counter never sits at zero while skipping.
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_ff != '0))
      else $error("header skip counter is zero in skip phase");

   // An image being emitted always has pixels left.
   a_pixels_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXELS) |-> (pixels_left_ff != '0))
      else $error("pixel phase with no pixels left");

   // The final pixel of an image has already been counted.
   a_last_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pixel_valid && rsp_ff.last_of_image) |->
      (rsp_ff.image_count == rsp_ff.image_index + 12'd1))
      else $error("image count not advanced on last pixel");

   // Finishing an image always returns to scanning through the resume phase.
   a_resume_after_image: assert property (@(posedge clock) disable iff (reset)
      (advance && pix && rsp_in.last_of_image) |=> (phase_ff == PH_RESUME))
      else $error("no resume phase after last pixel");

endmodule
